// ===== design/mpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpm_pkg
// Types and constants used by the multi-pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

  // Most results given for one text beat.
  localparam int unsigned MAX_RESULTS = 8;

  typedef enum logic [1:0] {
    OP_LOAD_CHAR = 2'd0,
    OP_LOAD_LEN  = 2'd1,
    OP_TEXT      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] slot;
    logic [3:0] offset;
    logic [7:0] symbol;
    logic [4:0] length_value;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  match_slot;
    logic [15:0] start_position;
    logic        overflow;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/mpm_ram.sv =====
// ----------------------------------------------------------------------------
// mpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/multi_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Naive multi-pattern matcher: patterns sit one per row in a RAM, and each
// text beat scans the rows against a shift-register history window.
// ----------------------------------------------------------------------------
// Load beats (character or length) read the row, then merge and write it
// back. A text beat scans every pattern row: the scan reads one pattern row
// per cycle from the single RAM read port, and a full output register stalls
// it. Each match waits in a pending register before the output register.
// Reset clears slot valid bits, history fill, position and saturation; the
// pattern RAM is never cleared, an unwritten slot reads as length zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_matcher #(
  parameter int unsigned NUM_PATTERNS    = 8,
  parameter int unsigned MAX_PATTERN_LEN = 16,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mpm_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mpm_pkg::out_item_t      out_data_o
);

  import mpm_pkg::*;

  localparam int unsigned SW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int unsigned NW    = $clog2(NUM_PATTERNS + 1);
  localparam int unsigned HW    = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned CHR_W = 8 * MAX_PATTERN_LEN;
  localparam int unsigned ROW_W = LEN_W + CHR_W;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [NUM_PATTERNS-1:0] slot_vld_q;
  logic [7:0]         hist_q [MAX_PATTERN_LEN];
  logic [LEN_W-1:0]   fill_q;
  logic [POSITION_BITS-1:0] pos_q, cur_q;
  logic               sat_q, clamped_q;

  // load beat held for the write-back cycle
  logic [SW-1:0]      wslot_q;
  op_e                wop_q;
  logic [3:0]         woffset_q;
  logic [7:0]         wsymbol_q;
  logic [LEN_W-1:0]   wlen_q;

  // scan
  logic               data_vld_q;
  logic [SW-1:0]      eval_idx_q;
  logic [NW-1:0]      next_rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               pend_vld_q;
  out_item_t          pend_q;
  out_item_t          pend_last;
  logic               out_valid_q;
  out_item_t          out_q;

  // RAM port
  logic               ram_re, ram_we;
  logic [SW-1:0]      ram_raddr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata;

  mpm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_PATTERNS)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic in_acc, slot_ok, off_ok, is_load, is_text;
  logic [LEN_W-1:0] len_clamped;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign slot_ok = int'(in_data_i.slot) < NUM_PATTERNS;
  assign off_ok  = int'(in_data_i.offset) < MAX_PATTERN_LEN;

  always_comb begin
    is_load = 1'b0;
    is_text = 1'b0;
    case (in_data_i.op)
      OP_LOAD_CHAR: is_load = slot_ok && off_ok;
      OP_LOAD_LEN:  is_load = slot_ok;
      OP_TEXT:      is_text = 1'b1;
      default:      ;
    endcase
  end

  always_comb begin
    if (int'(in_data_i.length_value) > MAX_PATTERN_LEN) begin
      len_clamped = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      len_clamped = LEN_W'(in_data_i.length_value);
    end
  end

  // --------------------------------------------------------------------------
  // Row compare against the history window
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]   row_len;
  logic [CHR_W-1:0]   row_chr;
  logic               row_ok;
  logic               match_hit;
  logic [HW-1:0]      hidx;
  logic [POSITION_BITS-1:0] start_pos;
  logic [POSITION_BITS+15:0] start_ext;
  out_item_t          new_res;

  assign row_chr = ram_rdata[CHR_W-1:0];
  assign row_len = slot_vld_q[eval_idx_q] ? ram_rdata[ROW_W-1:CHR_W] : '0;

  always_comb begin
    row_ok = (row_len != '0) && (row_len <= fill_q);
    hidx   = '0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      hidx = HW'(int'(row_len) - 1 - i);
      if (i < int'(row_len) && row_chr[i*8 +: 8] != hist_q[hidx]) begin
        row_ok = 1'b0;
      end
    end
  end

  assign match_hit = data_vld_q && row_ok && (cnt_q < CNT_W'(MAX_RESULTS));
  assign start_pos = cur_q - POSITION_BITS'(row_len) + POSITION_BITS'(1);
  assign start_ext = {16'b0, start_pos};

  always_comb begin
    new_res                = '0;
    new_res.match_slot     = 3'(eval_idx_q);
    new_res.start_position = start_ext[15:0];
    new_res.overflow       = clamped_q;
    new_res.last           = 1'b0;
  end

  always_comb begin
    pend_last      = pend_q;
    pend_last.last = 1'b1;
  end

  logic out_free, take, consumed, advance, scan_done, out_load;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign take      = match_hit && (!pend_vld_q || out_free);
  assign consumed  = data_vld_q && (!match_hit || take);
  assign advance   = !data_vld_q || consumed;
  assign scan_done = advance && (next_rd_q == NW'(NUM_PATTERNS));
  assign out_load  = (state_q == ST_SCAN && take && pend_vld_q) ||
                     (state_q == ST_FLUSH && pend_vld_q && out_free);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_load) begin
          state_d = ST_WRITE;
        end else if (in_acc && is_text) begin
          state_d = ST_SCAN;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && is_load) begin
          ram_re    = 1'b1;
          ram_raddr = SW'(in_data_i.slot);
        end else if (in_acc && is_text) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      ST_WRITE: ram_we = 1'b1;
      ST_SCAN: begin
        if (advance && next_rd_q < NW'(NUM_PATTERNS)) begin
          ram_re    = 1'b1;
          ram_raddr = next_rd_q[SW-1:0];
        end
      end
      ST_FLUSH: ;
      default: ;
    endcase
  end

  // merge the load beat into the row read back
  always_comb begin
    ram_wdata = slot_vld_q[wslot_q] ? ram_rdata : '0;
    case (wop_q)
      OP_LOAD_CHAR: begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          if (int'(woffset_q) == i) begin
            ram_wdata[i*8 +: 8] = wsymbol_q;
          end
        end
      end
      OP_LOAD_LEN: ram_wdata[ROW_W-1:CHR_W] = wlen_q;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (ram_we) begin
      slot_vld_q[wslot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_load) begin
      wslot_q   <= SW'(in_data_i.slot);
      wop_q     <= in_data_i.op;
      woffset_q <= in_data_i.offset;
      wsymbol_q <= in_data_i.symbol;
      wlen_q    <= len_clamped;
    end
  end

  // history window: shift in the text symbol, newest at index 0
  always_ff @(posedge clk_i) begin
    if (in_acc && is_text) begin
      for (int k = MAX_PATTERN_LEN - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= in_data_i.symbol;
    end
  end

  logic [LEN_W-1:0]         fill_base;
  logic [POSITION_BITS-1:0] pos_base;
  logic                     sat_base;

  assign fill_base = in_data_i.first ? '0 : fill_q;
  assign pos_base  = in_data_i.first ? '0 : pos_q;
  assign sat_base  = in_data_i.first ? 1'b0 : sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      sat_q  <= 1'b0;
    end else if (in_acc && is_text) begin
      if (fill_base < LEN_W'(MAX_PATTERN_LEN)) begin
        fill_q <= fill_base + LEN_W'(1);
      end else begin
        fill_q <= fill_base;
      end
      if (pos_base == POS_MAX) begin
        pos_q <= POS_MAX;
        sat_q <= 1'b1;
      end else begin
        pos_q <= pos_base + POSITION_BITS'(1);
        sat_q <= sat_base;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_text) begin
      cur_q     <= pos_base;
      clamped_q <= sat_base;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_vld_q <= 1'b0;
      eval_idx_q <= '0;
      next_rd_q  <= '0;
    end else if (state_q == ST_IDLE) begin
      if (in_acc && is_text) begin
        data_vld_q <= 1'b1;
        eval_idx_q <= '0;
        next_rd_q  <= NW'(1);
      end
    end else if (state_q == ST_SCAN && advance) begin
      data_vld_q <= ram_re;
      if (ram_re) begin
        eval_idx_q <= ram_raddr;
        next_rd_q  <= next_rd_q + NW'(1);
      end
    end
  end

  // hold one match back so the final one can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && is_text) begin
        cnt_q      <= '0;
        pend_vld_q <= 1'b0;
      end else if (state_q == ST_SCAN && take) begin
        cnt_q      <= cnt_q + CNT_W'(1);
        pend_vld_q <= 1'b1;
      end else if (state_q == ST_FLUSH && pend_vld_q && out_free) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && take) begin
      pend_q <= new_res;
      if (pend_vld_q) begin
        out_q <= pend_q;
      end
    end else if (state_q == ST_FLUSH && pend_vld_q && out_free) begin
      out_q <= pend_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(MAX_PATTERN_LEN))
    else $error("history fill beyond window");

  a_sat_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> pos_q == POS_MAX)
    else $error("saturated without position at max");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond limit");

  a_data_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> state_q == ST_SCAN)
    else $error("row data pending outside scan");

  a_flush_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH && state_d == ST_IDLE |=> !pend_vld_q)
    else $error("pending match left after flush");

endmodule

`default_nettype wire
